// ===== design/fewq_pkg.sv =====
// Package for the FIFO/EDF wait queue.
// Holds the result status codes; no dependencies.
`default_nettype none

package fewq_pkg;

	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== design/fewq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the queue entry store.
`default_nettype none

module fewq_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/fifo_or_edf_wait_queue.sv =====
// Top level of the FIFO/EDF wait queue: sequencer, ring pointers, result register.
// Depends on fewq_pkg and fewq_ram.
//
// Bounded wait queue of QUEUE_DEPTH entries kept as a ring in one RAM with a
// single read and a single write port. policy_edf selects arrival order (0) or
// earliest deadline first (1); ties on deadline put the higher id first. An
// item is taken only while the sequencer is idle, and its result goes to an
// output register, so the next item may be taken while a result waits. A FIFO
// enqueue, or an item rejected as full or empty, goes from dispatch straight to
// the result state; a grant first reads the head entry. An EDF enqueue walks
// the queue from the head, one entry per cycle through the RAM read port and
// one deadline/id comparator, then moves the later entries back one slot per
// cycle. A result that finds the output register still stalled holds the
// sequencer until it can be loaded. Policy writes are always taken.
`default_nettype none

module fifo_or_edf_wait_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8,
	parameter int TIME_WIDTH  = 48,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int EW = ID_WIDTH + TIME_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          policy_edf,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          func,
	input  wire logic [ID_WIDTH-1:0]           requester_id,
	input  wire logic [TIME_WIDTH-1:0]         deadline_time,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [fewq_pkg::STATUS_W-1:0]      status,
	output logic [ID_WIDTH-1:0]                granted_id,
	output logic [TIME_WIDTH-1:0]              granted_deadline,
	output logic [CW-1:0]                      occupancy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT_START,
		ST_SHIFT,
		ST_PLACE,
		ST_GRANT,
		ST_RESP
	} state_t;

	state_t                          state_q;
	logic                            policy_q;
	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   head_q;
	logic [CW-1:0]                   k_q;
	logic [CW-1:0]                   s_q;
	logic                            func_q;
	logic [ID_WIDTH-1:0]             id_q;
	logic [TIME_WIDTH-1:0]           dl_q;
	logic [fewq_pkg::STATUS_W-1:0]   res_status_q;
	logic [ID_WIDTH-1:0]             res_id_q;
	logic [TIME_WIDTH-1:0]           res_dl_q;
	logic                            out_valid_q;
	logic [fewq_pkg::STATUS_W-1:0]   status_q;
	logic [ID_WIDTH-1:0]             granted_id_q;
	logic [TIME_WIDTH-1:0]           granted_deadline_q;
	logic [CW-1:0]                   occupancy_q;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [AW-1:0]                   ram_raddr;
	logic [EW-1:0]                   ram_wdata;
	logic [EW-1:0]                   ram_rdata;
	logic [CW-1:0]                   rd_off;
	logic [CW-1:0]                   wr_off;
	logic [ID_WIDTH-1:0]             rd_id;
	logic [TIME_WIDTH-1:0]           rd_dl;
	logic                            goes_before;
	logic                            full;
	logic                            empty;
	logic                            out_free;

	// logical slot -> ring address
	function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_id       = ram_rdata[EW-1:TIME_WIDTH];
	assign rd_dl       = ram_rdata[TIME_WIDTH-1:0];
	assign goes_before = (dl_q < rd_dl) || ((dl_q == rd_dl) && (id_q > rd_id));
	assign full        = (count_q == CW'(QUEUE_DEPTH));
	assign empty       = (count_q == '0);
	assign out_free    = !out_valid_q || !out_stall;
	assign ram_raddr   = wrap_idx(head_q, rd_off);
	assign ram_waddr   = wrap_idx(head_q, wr_off);

	assign cfg_ready        = 1'b1;
	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign granted_id       = granted_id_q;
	assign granted_deadline = granted_deadline_q;
	assign occupancy        = occupancy_q;

	always_comb begin
		rd_off    = '0;
		wr_off    = '0;
		ram_we    = 1'b0;
		ram_wdata = {id_q, dl_q};
		case (state_q)
			ST_DISPATCH: begin
				if (!func_q && !full && !policy_q) begin
					ram_we = 1'b1;
					wr_off = count_q;
				end
			end
			ST_SCAN: begin
				rd_off = k_q + CW'(1);
			end
			ST_SHIFT_START: begin
				if (k_q != count_q) begin
					rd_off = count_q - CW'(1);
				end
			end
			ST_SHIFT: begin
				ram_we    = 1'b1;
				wr_off    = s_q;
				ram_wdata = ram_rdata;
				if ((s_q - CW'(1)) != k_q) begin
					rd_off = s_q - CW'(2);
				end else begin
					rd_off = k_q;
				end
			end
			ST_PLACE: begin
				ram_we = 1'b1;
				wr_off = k_q;
			end
			default: begin
			end
		endcase
	end

	fewq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			policy_q           <= 1'b0;
			count_q            <= '0;
			head_q             <= '0;
			k_q                <= '0;
			s_q                <= '0;
			func_q             <= 1'b0;
			id_q               <= '0;
			dl_q               <= '0;
			res_status_q       <= fewq_pkg::STATUS_OK;
			res_id_q           <= '0;
			res_dl_q           <= '0;
			out_valid_q        <= 1'b0;
			status_q           <= fewq_pkg::STATUS_OK;
			granted_id_q       <= '0;
			granted_deadline_q <= '0;
			occupancy_q        <= '0;
		end else begin
			if (cfg_valid) begin
				policy_q <= policy_edf;
			end
			if (out_valid_q && !out_stall && (state_q != ST_RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						id_q    <= requester_id;
						dl_q    <= deadline_time;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					res_id_q <= '0;
					res_dl_q <= '0;
					k_q      <= '0;
					if (func_q) begin
						if (empty) begin
							res_status_q <= fewq_pkg::STATUS_EMPTY;
							state_q      <= ST_RESP;
						end else begin
							res_status_q <= fewq_pkg::STATUS_OK;
							state_q      <= ST_GRANT;
						end
					end else if (full) begin
						res_status_q <= fewq_pkg::STATUS_FULL;
						state_q      <= ST_RESP;
					end else begin
						res_status_q <= fewq_pkg::STATUS_OK;
						if (!policy_q) begin
							count_q <= count_q + CW'(1);
							state_q <= ST_RESP;
						end else if (empty) begin
							state_q <= ST_SHIFT_START;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (goes_before) begin
						state_q <= ST_SHIFT_START;
					end else if ((k_q + CW'(1)) == count_q) begin
						k_q     <= count_q;
						state_q <= ST_SHIFT_START;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				ST_SHIFT_START: begin
					s_q <= count_q;
					if (k_q == count_q) begin
						state_q <= ST_PLACE;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if ((s_q - CW'(1)) == k_q) begin
						state_q <= ST_PLACE;
					end else begin
						s_q <= s_q - CW'(1);
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_RESP;
				end
				ST_GRANT: begin
					res_id_q <= rd_id;
					res_dl_q <= rd_dl;
					head_q   <= wrap_idx(head_q, CW'(1));
					count_q  <= count_q - CW'(1);
					state_q  <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						status_q           <= res_status_q;
						granted_id_q       <= res_id_q;
						granted_deadline_q <= res_dl_q;
						occupancy_q        <= count_q;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < QUEUE_DEPTH)
		else $error("head pointer out of range");

	a_shift_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (ram_waddr != ram_raddr))
		else $error("shift reads the slot it writes");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == fewq_pkg::STATUS_FULL))
			|-> (occupancy_q == CW'(QUEUE_DEPTH)))
		else $error("full status with queue not full");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == fewq_pkg::STATUS_EMPTY))
			|-> (occupancy_q == '0) && (granted_id_q == '0))
		else $error("empty status with entries or id");

	a_occ_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (occupancy_q == count_q))
		else $error("reported occupancy differs from count");
`endif

endmodule

`default_nettype wire

// ===== sim/fifo_or_edf_wait_queue_test.sv =====
// Self-checking testbench for fifo_or_edf_wait_queue: directed and random words
// in FIFO and EDF order, checked against a queue model kept in the testbench.
// Depends on fewq_pkg and the design sources.
module fifo_or_edf_wait_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int ID_W  = 8;
	localparam int T_W   = 48;
	localparam int CNT_W = 5;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_GRANT   = 1'b1;
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_EDF  = 1'b1;
	localparam logic [T_W-1:0] DL_MAX = {T_W{1'b1}};

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [T_W-1:0]  dl;
	} entry_t;

	typedef struct packed {
		logic [fewq_pkg::STATUS_W-1:0] status;
		logic [ID_W-1:0]               gid;
		logic [T_W-1:0]                gdl;
		logic [CNT_W-1:0]              occ;
	} result_t;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          policy_edf = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          func = 1'b0;
	logic [ID_W-1:0]               requester_id = '0;
	logic [T_W-1:0]                deadline_time = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [fewq_pkg::STATUS_W-1:0] status;
	logic [ID_W-1:0]               granted_id;
	logic [T_W-1:0]                granted_deadline;
	logic [CNT_W-1:0]              occupancy;

	entry_t  shadow_entries[$];
	logic    shadow_edf = POLICY_FIFO;
	result_t due_results[$];
	int      errors = 0;
	int      hold_cycles = 0;
	int      burst_left = 0;

	fifo_or_edf_wait_queue uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.policy_edf       (policy_edf),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.requester_id     (requester_id),
		.deadline_time    (deadline_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.granted_id       (granted_id),
		.granted_deadline (granted_deadline),
		.occupancy        (occupancy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[fifo_or_edf_wait_queue] ERROR");
		$finish;
	end

	function automatic result_t serve_request(input logic f, input logic [ID_W-1:0] id,
			input logic [T_W-1:0] dl);
		result_t r;
		entry_t  e;
		int      pos;
		r = '0;
		r.status = fewq_pkg::STATUS_OK;
		if (f == OP_ENQUEUE) begin
			if (shadow_entries.size() >= DEPTH) begin
				r.status = fewq_pkg::STATUS_FULL;
			end else begin
				e.id = id;
				e.dl = dl;
				pos = shadow_entries.size();
				if (shadow_edf == POLICY_EDF) begin
					pos = 0;
					while (pos < shadow_entries.size() &&
							!(dl < shadow_entries[pos].dl ||
							(dl == shadow_entries[pos].dl && id > shadow_entries[pos].id)))
						pos++;
				end
				shadow_entries.insert(pos, e);
			end
		end else begin
			if (shadow_entries.size() == 0) begin
				r.status = fewq_pkg::STATUS_EMPTY;
			end else begin
				e = shadow_entries.pop_front();
				r.gid = e.id;
				r.gdl = e.dl;
			end
		end
		r.occ = CNT_W'(shadow_entries.size());
		return r;
	endfunction

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got status %0d id 0x%0h",
					$time, status, granted_id);
			end else begin
				want = due_results.pop_front();
				report_field("status", 64'(want.status), 64'(status));
				report_field("granted_id", 64'(want.gid), 64'(granted_id));
				report_field("granted_deadline", 64'(want.gdl), 64'(granted_deadline));
				report_field("occupancy", 64'(want.occ), 64'(occupancy));
			end
		end
	end

	// receiver stall pattern, with forced hold-off
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       cyc;
		mode = RX_OPEN;
		mode_left = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN:     out_stall <= 1'b0;
					RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= ((cyc % 7) < 3);
				endcase
			end
		end
	end

	task automatic send_word(input logic f, input logic [ID_W-1:0] id,
			input logic [T_W-1:0] dl);
		@(negedge clk);
		in_valid <= 1'b1;
		func <= f;
		requester_id <= id;
		deadline_time <= dl;
		do @(posedge clk); while (in_stall);
		due_results.push_back(serve_request(f, id, dl));
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (due_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_policy(input logic v);
		idle_gap(1);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		policy_edf <= v;
		do @(posedge clk); while (!cfg_ready);
		shadow_edf = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 3) == 0)
			return ID_W'($urandom_range(0, 3));
		return ID_W'($urandom);
	endfunction

	function automatic logic [T_W-1:0] pick_deadline();
		case ($urandom_range(0, 5))
			0:       return ($urandom_range(0, 1) != 0) ? DL_MAX : '0;
			1, 2:    return T_W'($urandom_range(0, 15));
			default: return T_W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic test_grant_empty();
		set_policy(POLICY_FIFO);
		send_word(OP_GRANT, 8'hFF, DL_MAX);
	endtask

	task automatic test_fifo_order();
		send_word(OP_ENQUEUE, 8'hFF, DL_MAX);
		send_word(OP_ENQUEUE, 8'h00, '0);
		send_word(OP_ENQUEUE, 8'hA5, 48'h5555_AAAA_5555);
		repeat (3) send_word(OP_GRANT, 8'h00, '0);
	endtask

	task automatic test_edf_order();
		set_policy(POLICY_EDF);
		send_word(OP_ENQUEUE, 8'd1, 48'd100);
		send_word(OP_ENQUEUE, 8'd2, 48'd50);
		send_word(OP_ENQUEUE, 8'd3, 48'd100);   // tie: higher id first
		send_word(OP_ENQUEUE, 8'd3, 48'd100);   // identical entry
		send_word(OP_ENQUEUE, 8'd0, DL_MAX);
		send_word(OP_ENQUEUE, 8'd255, '0);
		repeat (6) send_word(OP_GRANT, 8'h00, '0);
	endtask

	task automatic test_policy_switch();
		set_policy(POLICY_FIFO);
		send_word(OP_ENQUEUE, 8'd1, 48'd30);
		send_word(OP_ENQUEUE, 8'd2, 48'd10);
		set_policy(POLICY_EDF);                 // queued order kept
		send_word(OP_ENQUEUE, 8'd3, 48'd20);
		repeat (3) send_word(OP_GRANT, 8'h00, '0);
	endtask

	task automatic test_fill_backpressure();
		set_policy(POLICY_EDF);
		@(posedge clk);
		hold_cycles = 300;
		repeat (DEPTH + 4) send_word(OP_ENQUEUE, pick_id(), pick_deadline());
		repeat (DEPTH + 1) send_word(OP_GRANT, pick_id(), pick_deadline());
	endtask

	task automatic test_random_traffic();
		int  enq_pct;
		logic f;
		for (int p = 0; p < 12; p++) begin
			set_policy((p % 4 == 1 || p % 4 == 2) ? POLICY_EDF : POLICY_FIFO);
			case (p % 3)
				0:       enq_pct = 75;
				1:       enq_pct = 50;
				default: enq_pct = 30;
			endcase
			burst_left = 0;
			for (int i = 0; i < 85; i++) begin
				f = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_GRANT;
				send_word(f, pick_id(), pick_deadline());
				if (p % 4 != 3) begin
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						idle_gap($urandom_range(1, 12));
						burst_left = $urandom_range(0, 24);
					end
				end
			end
		end
	endtask

	initial begin
		int waited;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_grant_empty();
		test_fifo_order();
		test_edf_order();
		test_policy_switch();
		test_fill_backpressure();
		test_random_traffic();
		idle_gap(1);
		waited = 0;
		while (due_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (due_results.size() != 0) begin
			errors++;
			$display("%0t: %0d words expected, none arrived", $time, due_results.size());
		end
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[fifo_or_edf_wait_queue] OK");
		else
			$display("[fifo_or_edf_wait_queue] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fewq_pkg.sv
design/fewq_ram.sv
design/fifo_or_edf_wait_queue.sv
sim/fifo_or_edf_wait_queue_test.sv
